/* rtl/irg_pkg.sv */
// Shared types, constants and microprogram for the instruction rate governor.
package irg_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_TARGET_MIPS = 2'd0;
  localparam logic [1:0] REG_CREDIT_CAP  = 2'd1;
  localparam logic [1:0] REG_WINDOW_LEN  = 2'd2;

  // Field and datapath widths
  localparam int MIPS_W  = 14;
  localparam int CAP_W   = 20;
  localparam int WLEN_W  = 30;
  localparam int CNT_W   = 12;
  localparam int NOW_W   = 62;
  localparam int STALL_W = 30;
  localparam int QCNT_W  = 13;
  localparam int WCNT_W  = 40;
  localparam int TIME_W  = 64;
  localparam int DUE_W   = 50;
  localparam int DIVC_W  = 6;
  localparam int THR_W   = 21;

  // Fixed constants of the accounting
  localparam logic [MIPS_W-1:0]  MIPS_RESET      = 14'd250;
  localparam logic [CAP_W-1:0]   CAP_RESET       = 20'd100000;
  localparam logic [WLEN_W-1:0]  WLEN_RESET      = 30'd250000000;
  localparam logic [THR_W-1:0]   INSN_PER_MIPS   = 21'd125;
  localparam logic [DUE_W-1:0]   NS_PER_US       = 50'd1000;
  localparam logic [TIME_W-1:0]  STALL_MAX       = 64'd1000000000;
  localparam logic [DIVC_W-1:0]  DIV_LAST        = 6'(DUE_W - 1);

  // Microprogram step addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] P_EMIT   = 5'd0;
  localparam logic [PC_W-1:0] P_WAIT   = 5'd1;
  localparam logic [PC_W-1:0] P_DISP   = 5'd2;
  localparam logic [PC_W-1:0] P_ADDQ   = 5'd3;
  localparam logic [PC_W-1:0] P_CHKQ   = 5'd4;
  localparam logic [PC_W-1:0] P_SETTLE = 5'd5;
  localparam logic [PC_W-1:0] P_DINIT  = 5'd6;
  localparam logic [PC_W-1:0] P_DIV    = 5'd7;
  localparam logic [PC_W-1:0] P_ELAP   = 5'd8;
  localparam logic [PC_W-1:0] P_DIFF   = 5'd9;
  localparam logic [PC_W-1:0] P_SIGN   = 5'd10;
  localparam logic [PC_W-1:0] P_SURP   = 5'd11;
  localparam logic [PC_W-1:0] P_FORG1  = 5'd12;
  localparam logic [PC_W-1:0] P_FORG2  = 5'd13;
  localparam logic [PC_W-1:0] P_NEG    = 5'd14;
  localparam logic [PC_W-1:0] P_STALL  = 5'd15;
  localparam logic [PC_W-1:0] P_ADV    = 5'd16;
  localparam logic [PC_W-1:0] P_WCHK   = 5'd17;
  localparam logic [PC_W-1:0] P_WCMP   = 5'd18;
  localparam logic [PC_W-1:0] P_START  = 5'd19;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_EMIT   = 4'd1,
    OP_LOAD   = 4'd2,
    OP_ADDQ   = 4'd3,
    OP_SETTLE = 4'd4,
    OP_DINIT  = 4'd5,
    OP_DIV    = 4'd6,
    OP_ELAP   = 4'd7,
    OP_DIFF   = 4'd8,
    OP_FORG1  = 4'd9,
    OP_FORG2  = 4'd10,
    OP_NEG    = 4'd11,
    OP_STALL  = 4'd12,
    OP_ADV    = 4'd13,
    OP_WCMP   = 4'd14,
    OP_START  = 4'd15
  } op_t;

  // Jump conditions: taken jumps go to the target, otherwise fall through
  typedef enum logic [3:0] {
    C_NEXT         = 4'd0,
    C_JUMP         = 4'd1,
    C_NO_INPUT     = 4'd2,
    C_START_CMD    = 4'd3,
    C_QUANTUM_OPEN = 4'd4,
    C_DIV_BUSY     = 4'd5,
    C_NEGATIVE     = 4'd6,
    C_CREDIT_OK    = 4'd7,
    C_OUT_BLOCKED  = 4'd8
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Control store
  function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: C_JUMP, target: P_WAIT};
    case (pc)
      P_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BLOCKED,  target: P_EMIT};
      P_WAIT:   w = '{op: OP_LOAD,   cond: C_NO_INPUT,     target: P_WAIT};
      P_DISP:   w = '{op: OP_NONE,   cond: C_START_CMD,    target: P_START};
      P_ADDQ:   w = '{op: OP_ADDQ,   cond: C_NEXT,         target: P_CHKQ};
      P_CHKQ:   w = '{op: OP_NONE,   cond: C_QUANTUM_OPEN, target: P_EMIT};
      P_SETTLE: w = '{op: OP_SETTLE, cond: C_NEXT,         target: P_DINIT};
      P_DINIT:  w = '{op: OP_DINIT,  cond: C_NEXT,         target: P_DIV};
      P_DIV:    w = '{op: OP_DIV,    cond: C_DIV_BUSY,     target: P_DIV};
      P_ELAP:   w = '{op: OP_ELAP,   cond: C_NEXT,         target: P_DIFF};
      P_DIFF:   w = '{op: OP_DIFF,   cond: C_NEXT,         target: P_SIGN};
      P_SIGN:   w = '{op: OP_NONE,   cond: C_NEGATIVE,     target: P_NEG};
      P_SURP:   w = '{op: OP_NONE,   cond: C_CREDIT_OK,    target: P_WCHK};
      P_FORG1:  w = '{op: OP_FORG1,  cond: C_NEXT,         target: P_FORG2};
      P_FORG2:  w = '{op: OP_FORG2,  cond: C_JUMP,         target: P_WCHK};
      P_NEG:    w = '{op: OP_NEG,    cond: C_NEXT,         target: P_STALL};
      P_STALL:  w = '{op: OP_STALL,  cond: C_NEXT,         target: P_ADV};
      P_ADV:    w = '{op: OP_ADV,    cond: C_NEXT,         target: P_WCHK};
      P_WCHK:   w = '{op: OP_ELAP,   cond: C_NEXT,         target: P_WCMP};
      P_WCMP:   w = '{op: OP_WCMP,   cond: C_JUMP,         target: P_EMIT};
      P_START:  w = '{op: OP_START,  cond: C_JUMP,         target: P_EMIT};
      default:  w = '{op: OP_NONE,   cond: C_JUMP,         target: P_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/instruction_rate_governor.sv */
// Instruction rate governor: microcoded credit-capped rate limiter.
// A start item passes the dispatch and start steps before its result is emitted;
// a block that closes no quantum passes the dispatch, add and quantum-check steps;
// a block that closes one also runs the 50-step restoring divider for the due time.
// Throughput: one item at a time; the next item is accepted the cycle after the
// result is loaded into the output register, which then waits for out_ready.
// Reset (synchronous, active high) restores the register defaults and clears counts.
module instruction_rate_governor
  import irg_pkg::*;
#(
  parameter int QUANTUM_CAP = 2000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [WLEN_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [CNT_W-1:0]    insn_count,
  input  logic [NOW_W-1:0]    now_ns,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STALL_W-1:0]  stall_ns,
  output logic                settled
);

  localparam logic [THR_W-1:0] QCAP = THR_W'(QUANTUM_CAP);

  // Configuration registers
  logic [MIPS_W-1:0] target_mips;
  logic [CAP_W-1:0]  credit_cap_ns;
  logic [WLEN_W-1:0] window_len_ns;

  // Sequencer and datapath registers
  logic [PC_W-1:0]          pc;
  logic [PC_W-1:0]          pc_next;
  logic                     cmd_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [TIME_W-1:0] now_r;
  logic signed [TIME_W-1:0] window_start;
  logic signed [TIME_W-1:0] acc;
  logic [QCNT_W-1:0]        quantum_count;
  logic [WCNT_W-1:0]        window_count;
  logic [DUE_W-1:0]         div_q;
  logic [MIPS_W-1:0]        div_rem;
  logic [DIVC_W-1:0]        div_cnt;
  logic [STALL_W-1:0]       stall_r;
  logic                     settled_r;

  ctrl_word_t               cw;
  logic                     in_fire;
  logic                     out_blocked;
  logic                     cond_true;
  logic [MIPS_W-1:0]        eff_mips;
  logic [THR_W-1:0]         thr_prod;
  logic [THR_W-1:0]         threshold;
  logic [WCNT_W:0]          wc_sum;
  logic [MIPS_W:0]          div_trial;
  logic                     div_bit;
  logic signed [TIME_W-1:0] due;
  logic signed [TIME_W-1:0] cap_s;
  logic signed [TIME_W-1:0] wlen_s;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (pc == P_WAIT);
  assign in_fire     = in_valid && in_ready;
  assign out_blocked = out_valid && !out_ready;
  assign cw          = rom_word(pc);

  // Derive quantum threshold and divisor from the configured rate
  assign eff_mips  = (target_mips == '0) ? MIPS_W'(1) : target_mips;
  assign thr_prod  = THR_W'(eff_mips) * INSN_PER_MIPS;
  assign threshold = (thr_prod > QCAP) ? QCAP : thr_prod;

  assign wc_sum    = {1'b0, window_count} + (WCNT_W + 1)'(quantum_count);
  assign div_trial = {div_rem, div_q[DUE_W-1]};
  assign div_bit   = (div_trial >= (MIPS_W + 1)'(eff_mips));
  assign due       = $signed(TIME_W'(div_q));
  assign cap_s     = $signed(TIME_W'(credit_cap_ns));
  assign wlen_s    = $signed(TIME_W'(window_len_ns));

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_mips   <= MIPS_RESET;
      credit_cap_ns <= CAP_RESET;
      window_len_ns <= WLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_MIPS: target_mips   <= cfg_data[MIPS_W-1:0];
        REG_CREDIT_CAP:  credit_cap_ns <= cfg_data[CAP_W-1:0];
        REG_WINDOW_LEN:  window_len_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  // Evaluate the jump condition of the current control word
  always_comb begin
    case (cw.cond)
      C_NEXT:         cond_true = 1'b0;
      C_JUMP:         cond_true = 1'b1;
      C_NO_INPUT:     cond_true = !in_fire;
      C_START_CMD:    cond_true = !cmd_r;
      C_QUANTUM_OPEN: cond_true = (THR_W'(quantum_count) < threshold);
      C_DIV_BUSY:     cond_true = (div_cnt != DIV_LAST);
      C_NEGATIVE:     cond_true = acc[TIME_W-1];
      C_CREDIT_OK:    cond_true = !(acc > cap_s);
      C_OUT_BLOCKED:  cond_true = out_blocked;
      default:        cond_true = 1'b0;
    endcase
    pc_next = cond_true ? cw.target : pc + PC_W'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Accounting state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_count <= '0;
      window_count  <= '0;
      window_start  <= '0;
    end else begin
      case (cw.op)
        OP_ADDQ:   quantum_count <= quantum_count + QCNT_W'(cnt_r);
        OP_SETTLE: begin
          window_count  <= wc_sum[WCNT_W] ? '1 : wc_sum[WCNT_W-1:0];
          quantum_count <= '0;
        end
        OP_FORG1:  window_start <= now_r - due;
        OP_FORG2:  window_start <= window_start - cap_s;
        OP_WCMP: begin
          if (acc > wlen_s) begin
            window_start <= now_r;
            window_count <= '0;
          end
        end
        OP_START: begin
          window_start  <= now_r;
          quantum_count <= '0;
          window_count  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers of the datapath
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_fire) begin
          cmd_r     <= command;
          cnt_r     <= insn_count;
          now_r     <= $signed({2'b00, now_ns});
          stall_r   <= '0;
          settled_r <= 1'b0;
        end
      end
      OP_SETTLE: settled_r <= 1'b1;
      OP_DINIT: begin
        div_q   <= DUE_W'(window_count) * NS_PER_US;
        div_rem <= '0;
        div_cnt <= '0;
      end
      OP_DIV: begin
        div_rem <= div_bit ? MIPS_W'(div_trial - (MIPS_W + 1)'(eff_mips))
                           : div_trial[MIPS_W-1:0];
        div_q   <= {div_q[DUE_W-2:0], div_bit};
        div_cnt <= div_cnt + DIVC_W'(1);
      end
      OP_ELAP:  acc <= now_r - window_start;
      OP_DIFF:  acc <= acc - due;
      OP_NEG:   acc <= -acc;
      OP_STALL: stall_r <= (acc > $signed(STALL_MAX)) ? STALL_MAX[STALL_W-1:0]
                                                       : acc[STALL_W-1:0];
      OP_ADV:   now_r <= now_r + $signed(TIME_W'(stall_r));
      default: ;
    endcase
  end

  // Hold the result until the consumer takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT && !out_blocked) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT && !out_blocked) begin
      stall_ns <= stall_r;
      settled  <= settled_r;
    end
  end

`ifndef NO_ASSERTIONS
  // Only one item is in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while an item was in flight");

  // A result that closed no quantum never stalls
  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !settled) |-> (stall_ns == '0))
    else $error("stall reported without a settled quantum");

  // The stall stays within its saturation bound
  a_stall_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (TIME_W'(stall_ns) <= STALL_MAX))
    else $error("stall exceeds saturation bound");
`endif

endmodule
